// ----- rtl/core/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg
// shared types and constants of the wildcard byte pattern scan
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int LEN_W       = 5;   // pattern length register width
	localparam int MASK_W      = 16;  // compare mask register width
	localparam int PAT_W       = 128; // both pattern byte registers together
	localparam int SEEN_W      = 33;  // saturating byte counter width
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int QUEUE_DEPTH = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEN    = 2'd3;

	typedef struct packed {
		logic [PAT_W-1:0]  pattern; // byte j in bits 8j+7..8j
		logic [MASK_W-1:0] mask;    // set: byte must match
		logic [LEN_W-1:0]  len;     // raw length, clamped where used
	} cfg_t;

endpackage

// ----- rtl/core/wbps_front.sv -----
// ----------------------------------------------------------------------------
// wbps_front
// byte window, byte counter and parallel pattern compare; pushes results
// ----------------------------------------------------------------------------
module wbps_front #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wbps_pkg::cfg_t         cfg,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	output logic                   push,
	output logic                   push_found,
	output logic [OFFSET_BITS-1:0] push_offset
);

	localparam int AGE_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [wbps_pkg::SEEN_W-1:0] SEEN_MAX = '1;

	logic [7:0]                    win_q [MAX_PATTERN];
	logic [7:0]                    win_n [MAX_PATTERN];
	logic [wbps_pkg::SEEN_W-1:0]   seen_q;
	logic [wbps_pkg::SEEN_W-1:0]   seen_n;
	logic                          done_q;
	logic [wbps_pkg::LEN_W-1:0]    len_eff;
	logic [MAX_PATTERN-1:0]        byte_ok;
	logic                          accept;
	logic                          hit;

	assign accept = in_valid & in_ready;

	// shifted window as it stands after this byte
	always_comb begin
		win_n[0] = data_byte;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win_n[i] = win_q[i-1];
		end
	end

	always_comb begin
		if (cfg.len == '0) begin
			len_eff = wbps_pkg::LEN_W'(1);
		end else if (cfg.len > wbps_pkg::LEN_W'(MAX_PATTERN)) begin
			len_eff = wbps_pkg::LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = cfg.len;
		end
	end

	assign seen_n = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;

	// pattern byte j lines up with window age len-1-j
	always_comb begin
		logic [wbps_pkg::LEN_W-1:0] age;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			age = len_eff - wbps_pkg::LEN_W'(j) - wbps_pkg::LEN_W'(1);
			if (wbps_pkg::LEN_W'(j) >= len_eff || !cfg.mask[j]) begin
				byte_ok[j] = 1'b1;
			end else begin
				byte_ok[j] = (win_n[age[AGE_W-1:0]] == cfg.pattern[8*j +: 8]);
			end
		end
	end

	assign hit = (seen_n >= wbps_pkg::SEEN_W'(len_eff)) && (&byte_ok);

	assign push        = accept && !done_q && (hit || last_byte);
	assign push_found  = hit;
	assign push_offset = hit ? OFFSET_BITS'(seen_n - wbps_pkg::SEEN_W'(len_eff)) : '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= win_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				seen_q <= '0;
				done_q <= 1'b0;
			end else begin
				seen_q <= seen_n;
				if (!done_q && hit) begin
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/wbps_queue.sv -----
// ----------------------------------------------------------------------------
// wbps_queue
// small result queue between the compare front and the output stage
// ----------------------------------------------------------------------------
module wbps_queue #(
	parameter int WIDTH = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty,
	output logic             full
);

	localparam int DEPTH = wbps_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign pop_data  = mem_q[rd_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/wbps_back.sv -----
// ----------------------------------------------------------------------------
// wbps_back
// output register stage: drains the queue onto the master stream
// ----------------------------------------------------------------------------
module wbps_back #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_not_empty,
	input  logic [OFFSET_BITS:0]   q_data,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_found,
	output logic [OFFSET_BITS-1:0] out_offset
);

	logic                   valid_q;
	logic                   found_q;
	logic [OFFSET_BITS-1:0] offset_q;

	assign q_pop      = q_not_empty && (!valid_q || out_ready);
	assign out_valid  = valid_q;
	assign out_found  = found_q;
	assign out_offset = offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			found_q  <= q_data[OFFSET_BITS];
			offset_q <= q_data[OFFSET_BITS-1:0];
		end
	end

endmodule

// ----- rtl/core/wildcard_byte_pattern_scan.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// first-match search for a wildcard byte pattern in a streamed image
// ----------------------------------------------------------------------------
// Takes one image byte per cycle on the slave stream (tlast marks the final
// byte) and looks for the first place where the configured pattern of 1 to
// MAX_PATTERN bytes matches; pattern bytes whose compare_mask bit is clear
// are wildcards. All window positions are compared in parallel in the cycle
// the byte is accepted, so the sustained rate is one item per clock. One
// result item leaves per image: found with the start offset at the first
// match, or not found at the last byte; later bytes of a matched image are
// swallowed. A result passes through the result queue, then the output
// register, before it is visible on the master stream. The input stalls
// only when the four-entry result queue is full, i.e. when the master side
// has held off several results. Configure through cfg_we/cfg_index/cfg_wdata
// only while idle; a pattern_length of 0 acts as 1 and values above
// MAX_PATTERN act as MAX_PATTERN.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
	parameter int MAX_PATTERN = 16, // 1..16 pattern bytes
	parameter int OFFSET_BITS = 32  // 16..32, match offset width
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	// image bytes in
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [7:0]                            s_tdata,  // data_byte
	input  logic                                  s_tlast,  // last_byte
	// results out
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((OFFSET_BITS+7)/8)*8-1:0]      m_tdata,  // match_offset
	output logic                                  m_tuser   // found
);

	localparam int TDATA_W = ((OFFSET_BITS + 7) / 8) * 8;

	wbps_pkg::cfg_t         cfg_q;
	logic                   push;
	logic                   push_found;
	logic [OFFSET_BITS-1:0] push_offset;
	logic                   q_pop;
	logic [OFFSET_BITS:0]   q_data;
	logic                   q_not_empty;
	logic                   q_full;
	logic [OFFSET_BITS-1:0] out_offset;

	// configuration registers, values as of reset until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern <= '0;
			cfg_q.mask    <= '1;
			cfg_q.len     <= wbps_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				wbps_pkg::REG_PAT_LO: cfg_q.pattern[63:0]   <= cfg_wdata;
				wbps_pkg::REG_PAT_HI: cfg_q.pattern[127:64] <= cfg_wdata;
				wbps_pkg::REG_MASK:   cfg_q.mask <= cfg_wdata[wbps_pkg::MASK_W-1:0];
				wbps_pkg::REG_LEN:    cfg_q.len  <= cfg_wdata[wbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// input is held off only by a full result queue
	assign s_tready = !q_full;

	// front: window, counter, compare
	wbps_front #(
		.MAX_PATTERN(MAX_PATTERN),
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.data_byte  (s_tdata),
		.last_byte  (s_tlast),
		.push       (push),
		.push_found (push_found),
		.push_offset(push_offset)
	);

	// decoupling queue, entry is {found, offset}
	wbps_queue #(
		.WIDTH(OFFSET_BITS + 1)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_found, push_offset}),
		.pop      (q_pop),
		.pop_data (q_data),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	// back: output register
	wbps_back #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_found  (m_tuser),
		.out_offset (out_offset)
	);

	assign m_tdata = TDATA_W'(out_offset);

	// a result is only ever written on an accepted byte
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (s_tvalid && s_tready))
		else $error("result written without an accepted item");

	// the queue never takes a result while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("result queue overflow");

	// not-found results carry a zero offset
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("not-found result with nonzero offset");

	// a pushed result reaches the output register no earlier than next cycle
	a_out_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(m_tvalid)) |-> $past(q_not_empty))
		else $error("output valid without a queued result");

endmodule

// ----- bench/tb_wildcard_byte_pattern_scan.sv -----
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scan
// self-checking bench for the wildcard byte pattern scan
// ----------------------------------------------------------------------------
// Image bytes go in on the slave stream and found/not-found results come back
// on the master stream. A behavioral scan model in this file tracks the byte
// window, the per-image byte count and the matched flag, and predicts the
// result, if any, of each accepted byte. Results are checked in order against
// expectations. A short scripted section covers reset state, length clamping,
// wildcards, short images and a match on the final byte. Random images then
// follow with planted pattern occurrences. Random configurations are loaded
// while the block is idle, under three idle mixes on the two streams.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_scan;

	localparam int MAX_PAT   = 16;
	localparam int OFF_W     = 32;
	localparam int LIMIT     = 400000;
	localparam int MAX_SHOWN = 10;

	typedef struct {
		bit          found;
		logic [31:0] offset;
	} scan_result_t;

	typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_t;

	// one line of the scripted section; typed rows carry their own expectation
	typedef struct {
		row_kind_t       kind;
		logic [1:0]      idx;
		logic [63:0]     value;
		logic [7:0]      data;
		bit              last;
		bit              typed;
		bit              exp_hit;
		bit              exp_found;
		logic [31:0]     exp_offset;
	} row_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [7:0]                      s_tdata   = '0;  // data_byte
	logic                            s_tlast   = 1'b0; // last_byte
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [OFF_W-1:0]                m_tdata;          // match_offset
	logic                            m_tuser;          // found

	// scan model state, reset values as after arst_n
	logic [63:0] cfg_pat_lo = '0;
	logic [63:0] cfg_pat_hi = '0;
	logic [15:0] cfg_mask   = 16'hFFFF;
	logic [4:0]  cfg_len    = 5'd1;
	logic [7:0]  hist [MAX_PAT] = '{default: 8'h00}; // entry 0 is the newest byte
	logic [32:0] seen       = '0;
	bit          done       = 1'b0;

	scan_result_t pending_results [$];
	row_t         script [$];
	int           mismatches    = 0;
	int           cycles        = 0;
	int           send_idle_pct = 28;
	int           recv_idle_pct = 76;

	wildcard_byte_pattern_scan #(
		.MAX_PATTERN(MAX_PAT),
		.OFFSET_BITS(OFF_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// length register as the compare logic sees it: 0 acts as 1, capped at 16
	function automatic int eff_len();
		int n;
		n = cfg_len;
		if (n < 1)
			n = 1;
		if (n > MAX_PAT)
			n = MAX_PAT;
		return n;
	endfunction

	function automatic logic [7:0] pat_byte(int j);
		logic [127:0] p;
		p = {cfg_pat_hi, cfg_pat_lo};
		return p[8*j +: 8];
	endfunction

	// queue one expected result behind those already waiting
	function automatic void add_pending(input scan_result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// shift one accepted byte into the window and decide the result, if any
	function automatic void scan_byte(input logic [7:0] d, input bit l,
			output bit has_res, output scan_result_t res);
		int  n;
		bit  hit;
		has_res    = 1'b0;
		res.found  = 1'b0;
		res.offset = '0;
		for (int i = MAX_PAT - 1; i > 0; i--)
			hist[i] = hist[i-1];
		hist[0] = d;
		if (seen != '1)
			seen = seen + 33'd1;
		if (!done) begin
			n   = eff_len();
			hit = (seen >= n);
			// pattern byte j lines up with the byte n-1-j positions back
			for (int j = 0; j < n; j++)
				if (cfg_mask[j] && hist[n-1-j] != pat_byte(j))
					hit = 1'b0;
			if (hit) begin
				done       = 1'b1;
				has_res    = 1'b1;
				res.found  = 1'b1;
				res.offset = 32'(seen - 33'(n));
			end else if (l) begin
				has_res = 1'b1;
			end
		end
		if (l) begin
			seen = '0;
			done = 1'b0;
		end
	endfunction

	// present one byte, with random gaps before it, and hold until taken
	task automatic send_byte(logic [7:0] d, bit l);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// stop sending and let every outstanding result drain before a register write
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [63:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wbps_pkg::REG_PAT_LO: cfg_pat_lo = v;
			wbps_pkg::REG_PAT_HI: cfg_pat_hi = v;
			wbps_pkg::REG_MASK:   cfg_mask   = v[15:0];
			wbps_pkg::REG_LEN:    cfg_len    = v[4:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic row_cfg(logic [1:0] idx, logic [63:0] v);
		row_t r;
		r = '{ROW_CFG, idx, v, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0};
		script.insert(script.size(), r);
	endtask

	task automatic row_byte(logic [7:0] d, bit l);
		row_t r;
		r = '{ROW_ITEM, wbps_pkg::REG_PAT_LO, 64'd0, d, l, 1'b0, 1'b0, 1'b0, 32'd0};
		script.insert(script.size(), r);
	endtask

	task automatic row_known(logic [7:0] d, bit l, bit hit, bit f, logic [31:0] off);
		row_t r;
		r = '{ROW_ITEM, wbps_pkg::REG_PAT_LO, 64'd0, d, l, 1'b1, hit, f, off};
		script.insert(script.size(), r);
	endtask

	// one image of random bytes, biased toward pattern bytes, usually with
	// the pattern planted somewhere in it
	task automatic send_image(output int n);
		logic [7:0]   img [64];
		int           len_e;
		int           pos;
		bit           has_res;
		scan_result_t res;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 20);
		for (int i = 0; i < n; i++)
			img[i] = $urandom_range(0, 1) ? pat_byte($urandom_range(0, MAX_PAT - 1))
			                              : 8'($urandom_range(0, 255));
		len_e = eff_len();
		if ($urandom_range(0, 3) != 0 && n >= len_e) begin
			pos = $urandom_range(0, n - len_e);
			for (int j = 0; j < len_e; j++)
				img[pos+j] = cfg_mask[j] ? pat_byte(j) : 8'($urandom_range(0, 255));
		end
		for (int i = 0; i < n; i++) begin
			send_byte(img[i], i == n - 1);
			scan_byte(img[i], i == n - 1, has_res, res);
			if (has_res)
				add_pending(res);
		end
	endtask

	// result side: random stalls, in-order compare against the expected results
	always @(posedge clk) begin : result_check
		scan_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result item: found %0b offset %0d",
						m_tuser, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (want.found !== m_tuser || want.offset !== m_tdata) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("result mismatch: found exp %0b got %0b, offset exp %0d got %0d",
							want.found, m_tuser, want.offset, m_tdata);
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		bit           has_res;
		scan_result_t res;
		logic [63:0]  v;
		int           n;
		int           sent;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset config: one-byte pattern 0x00, must match
		row_known(8'h00, 1'b0, 1'b1, 1'b1, 32'd0);
		// matched image swallows the rest, last byte still closes it
		row_known(8'hFF, 1'b0, 1'b0, 1'b0, 32'd0);
		row_known(8'hFF, 1'b1, 1'b0, 1'b0, 32'd0);
		// one-byte image without a match
		row_known(8'hFF, 1'b1, 1'b1, 1'b0, 32'd0);
		// length zero acts as one; upper write bits are dropped
		row_cfg(wbps_pkg::REG_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
		row_cfg(wbps_pkg::REG_PAT_LO, 64'h0000_0000_0000_00AB);
		row_known(8'h12, 1'b0, 1'b0, 1'b0, 32'd0);
		row_known(8'hAB, 1'b0, 1'b1, 1'b1, 32'd1);
		row_known(8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
		// length 31 caps at 16, all wildcards, image too short to hold it
		row_cfg(wbps_pkg::REG_LEN, 64'h0000_0000_0000_001F);
		row_cfg(wbps_pkg::REG_MASK, 64'hFFFF_FFFF_FFFF_0000);
		row_known(8'h5A, 1'b0, 1'b0, 1'b0, 32'd0);
		row_known(8'hA5, 1'b0, 1'b0, 1'b0, 32'd0);
		row_known(8'hC3, 1'b1, 1'b1, 1'b0, 32'd0);
		// mask bits above the length ignored: two wildcards match at once
		row_cfg(wbps_pkg::REG_LEN, 64'd2);
		row_cfg(wbps_pkg::REG_MASK, 64'h0000_0000_0000_FFFC);
		row_cfg(wbps_pkg::REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF);
		row_known(8'h01, 1'b0, 1'b0, 1'b0, 32'd0);
		row_known(8'hFE, 1'b0, 1'b1, 1'b1, 32'd0);
		row_known(8'h77, 1'b1, 1'b0, 1'b0, 32'd0);
		// exact two-byte pattern completing on the final byte
		row_cfg(wbps_pkg::REG_PAT_LO, 64'hFFFF_FFFF_FFFF_3412);
		row_cfg(wbps_pkg::REG_MASK, 64'h0000_0000_0000_FFFF);
		row_known(8'h00, 1'b0, 1'b0, 1'b0, 32'd0);
		row_known(8'h12, 1'b0, 1'b0, 1'b0, 32'd0);
		row_known(8'h34, 1'b1, 1'b1, 1'b1, 32'd1);
		// wildcard in the middle of a three-byte pattern
		row_cfg(wbps_pkg::REG_LEN, 64'd3);
		row_cfg(wbps_pkg::REG_PAT_LO, 64'h0000_0000_0056_0012);
		row_cfg(wbps_pkg::REG_MASK, 64'h0000_0000_0000_0005);
		row_known(8'h12, 1'b0, 1'b0, 1'b0, 32'd0);
		row_known(8'h99, 1'b0, 1'b0, 1'b0, 32'd0);
		row_known(8'h56, 1'b0, 1'b1, 1'b1, 32'd0);
		row_known(8'h80, 1'b1, 1'b0, 1'b0, 32'd0);
		row_byte(8'h00, 1'b0);
		row_byte(8'h12, 1'b0);
		row_byte(8'hFF, 1'b0);
		row_byte(8'h56, 1'b1);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				settle();
				cfg_write(script[i].idx, script[i].value);
			end else begin
				send_byte(script[i].data, script[i].last);
				scan_byte(script[i].data, script[i].last, has_res, res);
				if (script[i].typed) begin
					if (script[i].exp_hit) begin
						res.found  = script[i].exp_found;
						res.offset = script[i].exp_offset;
						add_pending(res);
					end
				end else if (has_res) begin
					add_pending(res);
				end
			end
		end

		// random images: slow receiver, then slow sender, then full rate
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 76 : 0;
			recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 28 : 0;
			for (int c = 0; c < 6; c++) begin
				settle();
				// pattern words: all zeros, all ones or random
				for (int w = 0; w < 2; w++) begin
					case ($urandom_range(0, 5))
						0:       v = '0;
						1:       v = '1;
						default: v = {$urandom, $urandom};
					endcase
					cfg_write(w == 0 ? wbps_pkg::REG_PAT_LO : wbps_pkg::REG_PAT_HI, v);
				end
				// mask: none, full or random, sometimes with junk above bit 15
				v = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
				case ($urandom_range(0, 5))
					0:       v[15:0] = 16'h0000;
					1:       v[15:0] = 16'hFFFF;
					default: v[15:0] = 16'($urandom_range(0, 65535));
				endcase
				cfg_write(wbps_pkg::REG_MASK, v);
				// length: mostly short so matches are common, extremes now and then
				v = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
				case ($urandom_range(0, 9))
					0:       v[4:0] = 5'd0;
					1:       v[4:0] = 5'd1;
					2:       v[4:0] = 5'd16;
					3:       v[4:0] = 5'd31;
					4:       v[4:0] = 5'($urandom_range(17, 30));
					default: v[4:0] = 5'($urandom_range(1, 6));
				endcase
				cfg_write(wbps_pkg::REG_LEN, v);
				sent = 0;
				while (sent < 35) begin
					send_image(n);
					sent += n;
				end
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/wbps_pkg.sv
rtl/core/wbps_front.sv
rtl/core/wbps_queue.sv
rtl/core/wbps_back.sv
rtl/core/wildcard_byte_pattern_scan.sv
bench/tb_wildcard_byte_pattern_scan.sv
